// ===== rtl/rgta_pkg.sv =====
// Package for the RDS group text assembler: command, store and group codes,
// store sizes and the input item type.
// Used by rds_group_text_assembler_core and the testbench; depends on nothing else.
package rgta_pkg;

	// Store sizes in characters
	localparam int NAME_CHARS = 8;
	localparam int RT_CHARS   = 64;

	// Radiotext memory is organised as rows of four characters
	localparam int RT_LANES = 4;
	localparam int RT_ROWS  = RT_CHARS / RT_LANES;
	localparam int RT_ROW_W = $clog2(RT_ROWS);

	// Commands
	localparam logic CMD_DECODE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// Group codes (type times two plus version bit)
	localparam logic [4:0] GC_0A  = 5'd0;
	localparam logic [4:0] GC_0B  = 5'd1;
	localparam logic [4:0] GC_2A  = 5'd4;
	localparam logic [4:0] GC_2B  = 5'd5;
	localparam logic [4:0] GC_10A = 5'd20;

	// Updated-store codes
	localparam logic [1:0] UPD_NONE = 2'd0;
	localparam logic [1:0] UPD_PS   = 2'd1;
	localparam logic [1:0] UPD_RT   = 2'd2;
	localparam logic [1:0] UPD_PTYN = 2'd3;

	// Store selects for a read
	localparam logic [1:0] SEL_PS   = 2'd0;
	localparam logic [1:0] SEL_RT   = 2'd1;
	localparam logic [1:0] SEL_PTYN = 2'd2;

	// One input item as held in the input register
	typedef struct packed {
		logic        command;
		logic [15:0] block_b;
		logic [15:0] block_c;
		logic [15:0] block_d;
		logic [1:0]  store_select;
		logic [5:0]  char_index;
	} item_t;

endpackage

// ===== rtl/rds_group_text_assembler_core.sv =====
// RDS group text assembler: decodes groups 0A/0B, 2A/2B and 10A into the
// service name, radiotext and type name stores, and reads stored characters.
// Depends on rgta_pkg.
//
// Usage. Items enter on the input channel (in_valid/in_ready) and every item
// gives exactly one result on the output channel (out_valid/out_ready).
// A decode item (command 0) carries blocks B, C and D of one RDS group; a read
// item (command 1) names a store and a character position and returns that
// character in read_char. The status fields decoder_id, text_ab and name_ab
// always show the state left behind by the item.
//
// Timing. An accepted item sits in the input register, where it is decoded
// and its writes are committed to the stores, until the output register is
// free or being emptied; its result is then offered from the output register.
// One item is taken per cycle while the output is not stalled; the rate is set
// by the single decode stage between the two registers.
//
// Reset clears all three stores, the decoder identification bits and both
// A/B flags, and empties both registers. The radiotext memory itself is not
// swept: a valid bit per character marks what has been written since the last
// clear, and an unmarked character reads as zero, so no clearing pass is needed.
//
// When the receiver stalls, the output register holds its result and the
// input register may still take one further item; after that in_ready drops
// until the output transfer completes.
module rds_group_text_assembler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [15:0] block_b,
	input  logic [15:0] block_c,
	input  logic [15:0] block_d,
	input  logic [1:0]  store_select,
	input  logic [5:0]  char_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  group_code,
	output logic [1:0]  updated_store,
	output logic        store_cleared,
	output logic [7:0]  read_char,
	output logic [3:0]  decoder_id,
	output logic        text_ab,
	output logic        name_ab
);

	// Handshake and input register
	logic                 accept;
	logic                 advance;
	logic                 valid_s1;
	rgta_pkg::item_t      item_s1;

	// Architectural state
	logic [7:0]           ps_q   [rgta_pkg::NAME_CHARS];
	logic [7:0]           ptyn_q [rgta_pkg::NAME_CHARS];
	logic [rgta_pkg::RT_CHARS-1:0] rt_vld_q;
	logic [31:0]          rt_mem [rgta_pkg::RT_ROWS];
	logic [3:0]           did_q;
	logic                 rt_ab_q;
	logic                 ptyn_ab_q;

	// Radiotext read path: registered memory data plus a forwarded write
	logic [31:0]          rt_rd_q;
	logic [3:0]           fwd_be_q;
	logic [31:0]          fwd_data_q;

	// Decode of the item in the input register
	logic [4:0]           code;
	logic [1:0]           kind;
	logic                 ab;
	logic [1:0]           ps_seg;
	logic                 ps_clr;
	logic                 rt_clr;
	logic                 ptyn_clr;
	logic [3:0]           did_next;
	logic                 rt_ab_next;
	logic                 ptyn_ab_next;
	logic                 rt_we;
	logic                 rt_commit;
	logic [rgta_pkg::RT_ROW_W-1:0] rt_row;
	logic [3:0]           rt_be;
	logic [31:0]          rt_wdata;
	logic [1:0]           rd_lane;
	logic [7:0]           rt_byte;
	logic [7:0]           rd_char;
	logic [4:0]           code_out;

	// Output register
	logic                 out_valid_q;
	logic [4:0]           group_code_q;
	logic [1:0]           updated_q;
	logic                 cleared_q;
	logic [7:0]           read_char_q;
	logic [3:0]           did_out_q;
	logic                 rt_ab_out_q;
	logic                 ptyn_ab_out_q;

	// The input register moves on whenever the output register is free or
	// is being emptied in this cycle; the item's writes commit at that edge.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{command: command, block_b: block_b, block_c: block_c,
				block_d: block_d, store_select: store_select,
				char_index: char_index};
		end
	end

	// Group decode. Only the three group families below touch any store;
	// a 10A group with any of block B bits 3:1 set is ignored.
	assign code = item_s1.block_b[15:11];
	assign ab   = item_s1.block_b[4];

	always_comb begin
		kind = rgta_pkg::UPD_NONE;
		if (item_s1.command == rgta_pkg::CMD_DECODE) begin
			unique case (code) inside
				rgta_pkg::GC_0A, rgta_pkg::GC_0B: begin
					kind = rgta_pkg::UPD_PS;
				end
				rgta_pkg::GC_2A, rgta_pkg::GC_2B: begin
					kind = rgta_pkg::UPD_RT;
				end
				rgta_pkg::GC_10A: begin
					if (item_s1.block_b[3:1] == 3'b000) begin
						kind = rgta_pkg::UPD_PTYN;
					end
				end
				default: begin
					kind = rgta_pkg::UPD_NONE;
				end
			endcase
		end
	end

	// Service name: segment 0 starts a fresh name and fresh decoder
	// identification; the identification bit lands at bit 3 minus segment.
	assign ps_seg = item_s1.block_b[1:0];
	assign ps_clr = (kind == rgta_pkg::UPD_PS) && (ps_seg == 2'd0);

	always_comb begin
		did_next = did_q;
		if (kind == rgta_pkg::UPD_PS) begin
			did_next = (ps_clr ? 4'd0 : did_q)
				| (4'(item_s1.block_b[2]) << (2'd3 - ps_seg));
		end
	end

	// The A/B flags clear their store whenever they change.
	assign rt_clr       = (kind == rgta_pkg::UPD_RT) && (ab != rt_ab_q);
	assign ptyn_clr     = (kind == rgta_pkg::UPD_PTYN) && (ab != ptyn_ab_q);
	assign rt_ab_next   = rt_clr ? ab : rt_ab_q;
	assign ptyn_ab_next = ptyn_clr ? ab : ptyn_ab_q;

	// Radiotext write. Lane j of a row holds character 4*row+j. A 2A group
	// fills a whole row with C then D; a 2B group fills half a row with D.
	assign rt_we     = (kind == rgta_pkg::UPD_RT);
	assign rt_commit = rt_we && advance;

	always_comb begin
		if (code == rgta_pkg::GC_2A) begin
			rt_row   = item_s1.block_b[3:0];
			rt_be    = 4'b1111;
			rt_wdata = {item_s1.block_d[7:0], item_s1.block_d[15:8],
				item_s1.block_c[7:0], item_s1.block_c[15:8]};
		end else begin
			rt_row   = {1'b0, item_s1.block_b[3:1]};
			rt_be    = item_s1.block_b[0] ? 4'b1100 : 4'b0011;
			rt_wdata = {item_s1.block_d[7:0], item_s1.block_d[15:8],
				item_s1.block_d[7:0], item_s1.block_d[15:8]};
		end
	end

	always_ff @(posedge clk) begin
		if (rt_commit) begin
			for (int j = 0; j < rgta_pkg::RT_LANES; j++) begin
				if (rt_be[j]) begin
					rt_mem[rt_row][j*8 +: 8] <= rt_wdata[j*8 +: 8];
				end
			end
		end
	end

	// The read is issued as the item is taken in. A write committed at that
	// same edge by the item ahead is caught by the forwarding register.
	always_ff @(posedge clk) begin
		if (accept) begin
			rt_rd_q    <= rt_mem[char_index[5:2]];
			fwd_be_q   <= (rt_commit && (rt_row == char_index[5:2])) ? rt_be : 4'b0000;
			fwd_data_q <= rt_wdata;
		end
	end

	// Store updates, all committed as the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rgta_pkg::NAME_CHARS; i++) begin
				ps_q[i]   <= 8'd0;
				ptyn_q[i] <= 8'd0;
			end
			rt_vld_q  <= '0;
			did_q     <= 4'd0;
			rt_ab_q   <= 1'b0;
			ptyn_ab_q <= 1'b0;
		end else if (advance) begin
			if (kind == rgta_pkg::UPD_PS) begin
				if (ps_clr) begin
					for (int i = 0; i < rgta_pkg::NAME_CHARS; i++) begin
						ps_q[i] <= 8'd0;
					end
				end
				ps_q[{ps_seg, 1'b0}] <= item_s1.block_d[15:8];
				ps_q[{ps_seg, 1'b1}] <= item_s1.block_d[7:0];
			end
			if (kind == rgta_pkg::UPD_PTYN) begin
				if (ptyn_clr) begin
					for (int i = 0; i < rgta_pkg::NAME_CHARS; i++) begin
						ptyn_q[i] <= 8'd0;
					end
				end
				ptyn_q[{item_s1.block_b[0], 2'b00}] <= item_s1.block_c[15:8];
				ptyn_q[{item_s1.block_b[0], 2'b01}] <= item_s1.block_c[7:0];
				ptyn_q[{item_s1.block_b[0], 2'b10}] <= item_s1.block_d[15:8];
				ptyn_q[{item_s1.block_b[0], 2'b11}] <= item_s1.block_d[7:0];
			end
			if (rt_we) begin
				if (rt_clr) begin
					rt_vld_q <= '0;
				end
				for (int j = 0; j < rgta_pkg::RT_LANES; j++) begin
					if (rt_be[j]) begin
						rt_vld_q[{rt_row, 2'(j)}] <= 1'b1;
					end
				end
			end
			did_q     <= did_next;
			rt_ab_q   <= rt_ab_next;
			ptyn_ab_q <= ptyn_ab_next;
		end
	end

	// Character read. Positions beyond an eight-character name and the
	// unused store select read as zero, as does any radiotext character not
	// written since the last clear.
	assign rd_lane = item_s1.char_index[1:0];
	assign rt_byte = fwd_be_q[rd_lane] ? fwd_data_q[{rd_lane, 3'b000} +: 8]
		: rt_rd_q[{rd_lane, 3'b000} +: 8];

	always_comb begin
		rd_char = 8'd0;
		if (item_s1.command == rgta_pkg::CMD_READ) begin
			case (item_s1.store_select)
				rgta_pkg::SEL_PS: begin
					if (item_s1.char_index[5:3] == 3'b000) begin
						rd_char = ps_q[item_s1.char_index[2:0]];
					end
				end
				rgta_pkg::SEL_RT: begin
					if (rt_vld_q[item_s1.char_index]) begin
						rd_char = rt_byte;
					end
				end
				rgta_pkg::SEL_PTYN: begin
					if (item_s1.char_index[5:3] == 3'b000) begin
						rd_char = ptyn_q[item_s1.char_index[2:0]];
					end
				end
				default: begin
					rd_char = 8'd0;
				end
			endcase
		end
	end

	assign code_out = (item_s1.command == rgta_pkg::CMD_DECODE) ? code : 5'd0;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			group_code_q  <= code_out;
			updated_q     <= kind;
			cleared_q     <= ps_clr || rt_clr || ptyn_clr;
			read_char_q   <= rd_char;
			did_out_q     <= did_next;
			rt_ab_out_q   <= rt_ab_next;
			ptyn_ab_out_q <= ptyn_ab_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign group_code    = group_code_q;
	assign updated_store = updated_q;
	assign store_cleared = cleared_q;
	assign read_char     = read_char_q;
	assign decoder_id    = did_out_q;
	assign text_ab       = rt_ab_out_q;
	assign name_ab       = ptyn_ab_out_q;

`ifndef SYNTH
	// A full input register behind a stalled output must not take more.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input accepted while both registers are held");

	// A radiotext clear always comes with a change of the A/B flag.
	a_rt_clear_flips_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && rt_clr) |=> (rt_ab_q != $past(rt_ab_q)))
		else $error("radiotext cleared without an A/B flag change");

	// After segment 0 the identification bits hold at most one set bit.
	a_ps_restart_did: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ps_clr) |=> ($countones(did_q) <= 1))
		else $error("decoder identification not restarted at segment 0");

	// A decode result never carries a read character.
	a_update_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (updated_q != rgta_pkg::UPD_NONE)) |-> (read_char_q == 8'd0))
		else $error("decode result carries a character");

	// A clear is only reported together with the store it cleared.
	a_clear_has_store: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && cleared_q) |-> (updated_q != rgta_pkg::UPD_NONE))
		else $error("clear reported without an updated store");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for rds_group_text_assembler_core: a directed table of groups
// and reads, then random traffic, scored against a text store predictor or typed-in results.
// Depends on rgta_pkg and the core itself; nothing else is read or needed.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Select code with no store behind it, and group codes that the core ignores.
	localparam logic [1:0] SEL_NONE  = 2'd3;
	localparam logic [4:0] GC_OTHER  = 5'd3;
	localparam logic [4:0] GC_TOP    = 5'd31;

	localparam int RANDOM_ITEMS = 1200;
	localparam int IDLE_LIMIT   = 3000;
	localparam int LONG_HOLD    = 250;
	localparam int DRAIN_CYCLES = 8;

	// One result as it leaves the output channel.
	typedef struct packed {
		logic [4:0] group_code;
		logic [1:0] updated_store;
		logic       store_cleared;
		logic [7:0] read_char;
		logic [3:0] decoder_id;
		logic       text_ab;
		logic       name_ab;
	} text_result_t;

	// One row of the directed table; fixed rows carry a result typed in by hand.
	typedef struct packed {
		rgta_pkg::item_t it;
		logic            fixed;
		text_result_t    res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [15:0] block_b;
	logic [15:0] block_c;
	logic [15:0] block_d;
	logic [1:0]  store_select;
	logic [5:0]  char_index;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  group_code;
	logic [1:0]  updated_store;
	logic        store_cleared;
	logic [7:0]  read_char;
	logic [3:0]  decoder_id;
	logic        text_ab;
	logic        name_ab;

	rds_group_text_assembler_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.block_b(block_b),
		.block_c(block_c),
		.block_d(block_d),
		.store_select(store_select),
		.char_index(char_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.group_code(group_code),
		.updated_store(updated_store),
		.store_cleared(store_cleared),
		.read_char(read_char),
		.decoder_id(decoder_id),
		.text_ab(text_ab),
		.name_ab(name_ab)
	);

	// The predictor's own copy of the three text stores and the status bits.
	logic [7:0] ps_text   [rgta_pkg::NAME_CHARS];
	logic [7:0] rt_text   [rgta_pkg::RT_CHARS];
	logic [7:0] ptyn_text [rgta_pkg::NAME_CHARS];
	logic [3:0] did_acc;
	logic       rt_flag;
	logic       ptyn_flag;

	text_result_t pending_results [$];
	stim_row_t    stim_rows [$];

	int errors       = 0;
	int results_seen = 0;
	int n_ps         = 0;
	int n_rt         = 0;
	int n_ptyn       = 0;
	int n_reads      = 0;
	int n_clears     = 0;
	int n_other      = 0;

	// Pacing flags; calm and long_hold are seen by both the sender and the receiver.
	bit calm      = 0;
	bit long_hold = 0;
	bit hold_done = 0;
	int hold_left = 0;
	int stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Works out the result of one item and commits its writes to the predicted
	// stores, exactly as the core should within its decode stage.
	function automatic text_result_t assemble_group(rgta_pkg::item_t it);
		text_result_t r;
		int           seg;
		int           pos;
		r = '0;
		if (it.command == rgta_pkg::CMD_READ) begin
			case (it.store_select)
				rgta_pkg::SEL_PS:
					r.read_char = (it.char_index < rgta_pkg::NAME_CHARS)
						? ps_text[it.char_index] : 8'h00;
				rgta_pkg::SEL_RT:
					r.read_char = rt_text[it.char_index];
				rgta_pkg::SEL_PTYN:
					r.read_char = (it.char_index < rgta_pkg::NAME_CHARS)
						? ptyn_text[it.char_index] : 8'h00;
				default:  r.read_char = 8'h00;
			endcase
		end else begin
			r.group_code = it.block_b[15:11];
			case (it.block_b[15:11])
				rgta_pkg::GC_0A, rgta_pkg::GC_0B: begin
					// Segment 0 starts a fresh service name and decoder id.
					seg = it.block_b[1:0];
					r.updated_store = rgta_pkg::UPD_PS;
					if (seg == 0) begin
						foreach (ps_text[k]) ps_text[k] = 8'h00;
						did_acc = 4'h0;
						r.store_cleared = 1'b1;
					end
					ps_text[2 * seg]     = it.block_d[15:8];
					ps_text[2 * seg + 1] = it.block_d[7:0];
					did_acc[3 - seg] = did_acc[3 - seg] | it.block_b[2];
				end
				rgta_pkg::GC_2A, rgta_pkg::GC_2B: begin
					// A flip of the A/B bit means a new radiotext message.
					seg = it.block_b[3:0];
					r.updated_store = rgta_pkg::UPD_RT;
					if (it.block_b[4] != rt_flag) begin
						rt_flag = it.block_b[4];
						foreach (rt_text[k]) rt_text[k] = 8'h00;
						r.store_cleared = 1'b1;
					end
					if (it.block_b[15:11] == rgta_pkg::GC_2A) begin
						pos = 4 * seg;
						rt_text[pos]     = it.block_c[15:8];
						rt_text[pos + 1] = it.block_c[7:0];
						rt_text[pos + 2] = it.block_d[15:8];
						rt_text[pos + 3] = it.block_d[7:0];
					end else begin
						pos = 2 * seg;
						rt_text[pos]     = it.block_d[15:8];
						rt_text[pos + 1] = it.block_d[7:0];
					end
				end
				rgta_pkg::GC_10A: begin
					// Only segments with address bits 3:1 clear carry the type name.
					if (it.block_b[3:1] == 3'b000) begin
						pos = it.block_b[0] ? 4 : 0;
						r.updated_store = rgta_pkg::UPD_PTYN;
						if (it.block_b[4] != ptyn_flag) begin
							ptyn_flag = it.block_b[4];
							foreach (ptyn_text[k]) ptyn_text[k] = 8'h00;
							r.store_cleared = 1'b1;
						end
						ptyn_text[pos]     = it.block_c[15:8];
						ptyn_text[pos + 1] = it.block_c[7:0];
						ptyn_text[pos + 2] = it.block_d[15:8];
						ptyn_text[pos + 3] = it.block_d[7:0];
					end
				end
				default: ;
			endcase
		end
		r.decoder_id = did_acc;
		r.text_ab    = rt_flag;
		r.name_ab    = ptyn_flag;
		return r;
	endfunction

	// Mostly short gaps, a few long ones, none at all in the calm stretch or the long hold.
	function automatic int pick_gap();
		int r;
		if (calm || long_hold)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Random traffic is mostly well-formed groups; the A/B bits usually follow
	// the current flags so that the stores fill up before they are cleared.
	function automatic rgta_pkg::item_t random_item();
		rgta_pkg::item_t it;
		int              r;
		it.command      = rgta_pkg::CMD_DECODE;
		it.block_b      = 16'($urandom);
		it.block_c      = 16'($urandom);
		it.block_d      = 16'($urandom);
		it.store_select = 2'($urandom_range(0, 3));
		it.char_index   = 6'($urandom_range(0, 63));
		r = $urandom_range(0, 99);
		if (r < 30) begin
			it.command = rgta_pkg::CMD_READ;
			if (it.store_select != rgta_pkg::SEL_RT && $urandom_range(0, 3) != 0)
				it.char_index = 6'($urandom_range(0, rgta_pkg::NAME_CHARS - 1));
		end else if (r < 55) begin
			it.block_b[15:11] = $urandom_range(0, 1) ? rgta_pkg::GC_0B : rgta_pkg::GC_0A;
		end else if (r < 80) begin
			it.block_b[15:11] = $urandom_range(0, 1) ? rgta_pkg::GC_2B : rgta_pkg::GC_2A;
			if ($urandom_range(0, 99) < 85)
				it.block_b[4] = rt_flag;
		end else if (r < 95) begin
			it.block_b[15:11] = rgta_pkg::GC_10A;
			if ($urandom_range(0, 4) != 0)
				it.block_b[3:1] = 3'b000;
			if ($urandom_range(0, 99) < 85)
				it.block_b[4] = ptyn_flag;
		end
		return it;
	endfunction

	function automatic void add_row(logic cmd, logic [15:0] b, logic [15:0] c,
			logic [15:0] d, logic [1:0] sel, logic [5:0] idx, logic fixed,
			logic [4:0] gc);
		stim_row_t row;
		row.it.command      = cmd;
		row.it.block_b      = b;
		row.it.block_c      = c;
		row.it.block_d      = d;
		row.it.store_select = sel;
		row.it.char_index   = idx;
		row.fixed           = fixed;
		row.res             = '0;
		row.res.group_code  = gc;
		stim_rows.push_back(row);
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Offers one item after a random gap and holds it until the transfer is
	// taken; valid stays high when the next item follows with no gap.
	task automatic transfer_item(input rgta_pkg::item_t it, input logic fixed,
			input text_result_t fixed_res);
		int           gap;
		text_result_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= it.command;
		block_b      <= it.block_b;
		block_c      <= it.block_c;
		block_d      <= it.block_d;
		store_select <= it.store_select;
		char_index   <= it.char_index;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = assemble_group(it);
		pending_results.push_back(fixed ? fixed_res : pred);
		if (it.command == rgta_pkg::CMD_READ)
			n_reads++;
		else case (pred.updated_store)
			rgta_pkg::UPD_PS:   n_ps++;
			rgta_pkg::UPD_RT:   n_rt++;
			rgta_pkg::UPD_PTYN: n_ptyn++;
			default:            n_other++;
		endcase
		if (pred.store_cleared)
			n_clears++;
	endtask

	// Sender: reset, the directed table, then random traffic.
	initial begin
		in_valid     = 1'b0;
		command      = rgta_pkg::CMD_DECODE;
		block_b      = '0;
		block_c      = '0;
		block_d      = '0;
		store_select = rgta_pkg::SEL_PS;
		char_index   = '0;
		arst_n       = 1'b0;
		foreach (ps_text[k]) ps_text[k] = 8'h00;
		foreach (rt_text[k]) rt_text[k] = 8'h00;
		foreach (ptyn_text[k]) ptyn_text[k] = 8'h00;
		did_acc   = 4'h0;
		rt_flag   = 1'b0;
		ptyn_flag = 1'b0;

		// Straight after reset every store reads as zero, reads past the end of a
		// store and the unused select read zero, and unknown groups change nothing.
		add_row(rgta_pkg::CMD_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, rgta_pkg::SEL_PS, 6'd0,
			1'b1, 5'd0);
		add_row(rgta_pkg::CMD_READ, 16'h0000, 16'h0000, 16'h0000, rgta_pkg::SEL_RT, 6'd63,
			1'b1, 5'd0);
		add_row(rgta_pkg::CMD_READ, 16'h0000, 16'h0000, 16'h0000, rgta_pkg::SEL_PTYN, 6'd7,
			1'b1, 5'd0);
		add_row(rgta_pkg::CMD_READ, 16'h0000, 16'h0000, 16'h0000, rgta_pkg::SEL_PS, 6'd8,
			1'b1, 5'd0);
		add_row(rgta_pkg::CMD_READ, 16'h0000, 16'h0000, 16'h0000, rgta_pkg::SEL_PTYN, 6'd63,
			1'b1, 5'd0);
		add_row(rgta_pkg::CMD_READ, 16'h0000, 16'h0000, 16'h0000, SEL_NONE, 6'd63,
			1'b1, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {GC_OTHER, 11'h7FF}, 16'hFFFF, 16'hFFFF, SEL_NONE,
			6'd63, 1'b1, GC_OTHER);
		add_row(rgta_pkg::CMD_DECODE, {GC_TOP, 11'h7FF}, 16'hFFFF, 16'hFFFF, SEL_NONE,
			6'd63, 1'b1, GC_TOP);

		// Service name: all four segments, decoder id bits, then a fresh segment 0.
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_0A, 11'h004}, 16'h0000, 16'h5241,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_0A, 11'h005}, 16'h0000, 16'h4449,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_0B, 11'h002}, 16'h0000, 16'h4F20,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_0B, 11'h007}, 16'h0000, 16'hFFFF,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_READ, 16'h0000, 16'h0000, 16'h0000, rgta_pkg::SEL_PS, 6'd7,
			1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_0A, 11'h000}, 16'h0000, 16'h0000,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_0A, 11'h7FF}, 16'hFFFF, 16'hFFFF,
			SEL_NONE, 6'd63, 1'b0, 5'd0);

		// Radiotext: A/B flip, first and last segments of both versions, flip back.
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_2A, 11'h010}, 16'h4142, 16'h4344,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_2A, 11'h01F}, 16'hFFFF, 16'hFFFF,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_2B, 11'h01F}, 16'h0000, 16'h5A5A,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_READ, 16'h0000, 16'h0000, 16'h0000, rgta_pkg::SEL_RT, 6'd63,
			1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_2B, 11'h000}, 16'h0000, 16'h4546,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_READ, 16'h0000, 16'h0000, 16'h0000, rgta_pkg::SEL_RT, 6'd60,
			1'b0, 5'd0);

		// Type name: both halves, two skipped segments, then an A/B flip.
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_10A, 11'h000}, 16'h5452, 16'h4146,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_10A, 11'h001}, 16'h4649, 16'h4320,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_10A, 11'h00E}, 16'hFFFF, 16'hFFFF,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_10A, 11'h012}, 16'hFFFF, 16'hFFFF,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_DECODE, {rgta_pkg::GC_10A, 11'h011}, 16'h4E45, 16'h5753,
			rgta_pkg::SEL_PS, 6'd0, 1'b0, 5'd0);
		add_row(rgta_pkg::CMD_READ, 16'h0000, 16'h0000, 16'h0000, rgta_pkg::SEL_PTYN, 6'd4,
			1'b0, 5'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[k])
			transfer_item(stim_rows[k].it, stim_rows[k].fixed, stim_rows[k].res);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 200 && i < 300);
			// Halfway through, the sender stops until the pipeline is empty.
			if (i == RANDOM_ITEMS / 2) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			transfer_item(random_item(), 1'b0, '0);
		end
		in_valid <= 1'b0;

		// Let every result drain, then keep the clock running for anything stray.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d service name, %0d radiotext, %0d type name, %0d other groups,",
			n_ps, n_rt, n_ptyn, n_other);
		$display("tb: %0d reads and %0d store clears; %0d results scored, %0d errors",
			n_reads, n_clears, results_seen, errors);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// Receiver: scores every output transfer against the oldest expectation and
	// paces out_ready. Once, well into the run, it holds off for a long stretch
	// so that both registers fill and the input side stalls.
	initial begin : receiver
		text_result_t got;
		text_result_t want;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {group_code, updated_store, store_cleared, read_char,
					decoder_id, text_ab, name_ab};
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, got);
					errors++;
				end else begin
					want = pending_results.pop_front();
					compare_field("group_code", want.group_code, got.group_code);
					compare_field("updated_store", want.updated_store, got.updated_store);
					compare_field("store_cleared", want.store_cleared, got.store_cleared);
					compare_field("read_char", want.read_char, got.read_char);
					compare_field("decoder_id", want.decoder_id, got.decoder_id);
					compare_field("text_ab", want.text_ab, got.text_ab);
					compare_field("name_ab", want.name_ab, got.name_ab);
				end
				results_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
				if (hold_left == 0)
					long_hold = 0;
			end else if (!hold_done && results_seen >= 800) begin
				hold_done = 1;
				long_hold = 1;
				hold_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// Watchdog: ends the run if no transfer happens on either channel for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
		$display("tb: done, errors");
		$finish;
	end

endmodule
